@@ sv/bpt_pkg.sv @@
// Shared constants, types and helpers for the border and period tracker.
package bpt_pkg;

  // Longest string that is stored; later bytes only raise overflow
  localparam int MAX_LEN  = 1024;
  // Width of a length or border count (must hold MAX_LEN itself)
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  // Address widths of the byte store and the border table
  localparam int STORE_AW = $clog2(MAX_LEN);
  localparam int TAB_AW   = LEN_W;
  localparam int TAB_DEPTH = MAX_LEN + 1;

  // Fixed field widths on the ports
  localparam int SYM_W = 8;
  localparam int PL_W  = 11;
  localparam int BL_W  = 10;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DONE
  } seq_state_t;

  // Byte store request: one write and one read address per cycle
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [SYM_W-1:0]    wdata;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  // Border table request: one write and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic [TAB_AW-1:0] raddr;
  } table_req_t;

  // One result item
  typedef struct packed {
    logic [PL_W-1:0] period;
    logic [BL_W-1:0] border_length;
    logic [PL_W-1:0] prefix_length;
    logic            overflow;
  } res_t;

  // Build a result from a length and its border
  function automatic res_t make_res(input logic [LEN_W-1:0] len,
                                    input logic [LEN_W-1:0] brd,
                                    input logic             ovf);
    res_t r;
    logic [LEN_W-1:0] per;
    per = len - brd;
    r.prefix_length = PL_W'(len);
    r.border_length = BL_W'(brd);
    r.period        = PL_W'(per);
    r.overflow      = ovf;
    return r;
  endfunction

endpackage

@@ sv/bpt_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
module bpt_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bpt_seq.sv @@
// Sequencer: fallback walk over the border table, length state and result register.
module bpt_seq
  import bpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_start_new,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res,
  output store_req_t       store_req,
  input  logic [SYM_W-1:0] store_q,
  output table_req_t       table_req,
  input  logic [LEN_W-1:0] table_q
);

  localparam logic [LEN_W-1:0] MaxLenL = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] OneL    = LEN_W'(1);

  seq_state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] matched_r, matched_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;
  res_t             pend_r, pend_nxt;

  logic [LEN_W-1:0] len_eff, match_eff, j0, jn, jf, j_rd;
  logic             ovf_eff, finish, go_check, mismatch, out_free;
  res_t             res;

  // Effective state once a start flag has cleared it
  assign len_eff   = in_start_new ? '0 : len_r;
  assign match_eff = in_start_new ? '0 : matched_r;
  assign ovf_eff   = in_start_new ? 1'b0 : ovf_r;
  assign mismatch  = (store_q != sym_r);
  assign out_free  = !out_valid_r || out_ready;

  // Datapath: take a request, walk the table, finish a byte
  always_comb begin
    len_nxt     = len_r;
    matched_nxt = matched_r;
    ovf_nxt     = ovf_r;
    j_nxt       = j_r;
    sym_nxt     = sym_r;
    finish      = 1'b0;
    go_check    = 1'b0;
    res         = '0;
    store_req   = '0;
    table_req   = '0;
    j_rd        = '0;
    j0          = '0;
    jn          = '0;
    jf          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          len_nxt     = len_eff;
          matched_nxt = match_eff;
          ovf_nxt     = ovf_eff;
          sym_nxt     = in_symbol;
          if (len_eff >= MaxLenL) begin
            // Past the end: flag overflow and repeat the last figures
            ovf_nxt = 1'b1;
            finish  = 1'b1;
            res     = make_res(len_eff, match_eff, 1'b1);
          end else begin
            store_req.we    = 1'b1;
            store_req.waddr = len_eff[STORE_AW-1:0];
            store_req.wdata = in_symbol;
            if (len_eff == '0) begin
              // First byte: border 0, period 1
              table_req.we    = 1'b1;
              table_req.waddr = OneL;
              table_req.wdata = '0;
              len_nxt         = OneL;
              matched_nxt     = '0;
              finish          = 1'b1;
              res             = make_res(OneL, '0, ovf_eff);
            end else begin
              // Start the walk at the current border
              j0       = (match_eff >= len_eff) ? '0 : match_eff;
              j_nxt    = j0;
              j_rd     = j0;
              go_check = 1'b1;
            end
          end
        end
      end
      S_CHECK: begin
        if (j_r != '0 && mismatch) begin
          // Fall back to the border of the border
          jn    = (table_q < j_r) ? table_q : '0;
          j_nxt = jn;
          j_rd  = jn;
        end else begin
          // Extend the border or drop to nothing
          jf              = mismatch ? '0 : j_r + OneL;
          table_req.we    = 1'b1;
          table_req.waddr = len_r + OneL;
          table_req.wdata = jf;
          len_nxt         = len_r + OneL;
          matched_nxt     = jf;
          finish          = 1'b1;
          res             = make_res(len_r + OneL, jf, ovf_r);
        end
      end
      S_DONE: begin
      end
    endcase
    store_req.raddr = j_rd[STORE_AW-1:0];
    table_req.raddr = j_rd[TAB_AW-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (finish) begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end else if (go_check) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (finish) begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Result register and the parked result behind it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    pend_nxt      = pend_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish && out_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (finish) begin
      pend_nxt = res;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = pend_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      matched_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      matched_r   <= matched_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    sym_r     <= sym_nxt;
    out_res_r <= out_res_nxt;
    pend_r    <= pend_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ sv/border_and_period_tracker_top.sv @@
// Top level of the border and period tracker: sequencer and its two memories.
//
// Takes one byte per request (tuser high starts a new string) and returns one
// result per byte: prefix length, longest proper border and minimum period.
// The bytes and the border table sit in two synchronous RAMs with registered
// reads. The first byte of a string and bytes beyond MAX_LEN finish in the idle
// state; any other byte goes on to the check state, steps back through the
// border table there, and those steps average under one per byte over a string.
// A byte whose result finds the result register still full parks that result
// and holds the input for as long as the receiver leaves the older result
// waiting. Bytes beyond MAX_LEN change nothing and return the previous figures
// with overflow set until the next string starts.
// No clearing pass is needed after reset.
module border_and_period_tracker_top
  import bpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tuser,   // [0] start_new
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [10:0] prefix_length, [20:11] border_length,
                                  // [31:21] period
  output logic        out_tuser   // [0] overflow
);

  store_req_t       store_req;
  table_req_t       table_req;
  logic [SYM_W-1:0] store_q;
  logic [LEN_W-1:0] table_q;
  res_t             res;

  bpt_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_symbol    (in_tdata),
    .in_start_new (in_tuser),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res),
    .store_req    (store_req),
    .store_q      (store_q),
    .table_req    (table_req),
    .table_q      (table_q)
  );

  // Bytes of the current string
  bpt_ram #(
    .Depth (MAX_LEN),
    .Width (SYM_W)
  ) u_byte_store (
    .clk   (clk),
    .we    (store_req.we),
    .waddr (store_req.waddr),
    .wdata (store_req.wdata),
    .raddr (store_req.raddr),
    .rdata (store_q)
  );

  // Border of every prefix length
  bpt_ram #(
    .Depth (TAB_DEPTH),
    .Width (LEN_W)
  ) u_border_table (
    .clk   (clk),
    .we    (table_req.we),
    .waddr (table_req.waddr),
    .wdata (table_req.wdata),
    .raddr (table_req.raddr),
    .rdata (table_q)
  );

  // Pack the result onto the stream
  assign out_tdata = {res.period, res.border_length, res.prefix_length};
  assign out_tuser = res.overflow;

endmodule
